// ===== rtl/selm_pkg.sv =====
// Shared types, constants and the log2 table generator for the stereo level meter.
// No dependencies; imported by selm_lane and the top level.
`default_nettype none

package selm_pkg;

    // Widths fixed by the register map and the result format
    localparam int COEFF_W = 24;
    localparam int DB_W    = 16;
    localparam int LOG_W   = 16;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_RELEASE = 2'd1;
    localparam logic [1:0] REG_STEREO  = 2'd2;

    // Register reset values
    localparam logic [COEFF_W-1:0] ATTACK_RESET  = 24'd34914;
    localparam logic [COEFF_W-1:0] RELEASE_RESET = 24'd1165;
    localparam logic               STEREO_RESET  = 1'b1;

    // dB conversion: 20*log10(2) in Q16, floor of -100 dB in Q8.8
    localparam int                 DB_PER_OCT_W  = 19;
    localparam logic [DB_PER_OCT_W-1:0] DB_PER_OCT = 19'd394566;
    localparam int                 DB_FLOOR_MAG  = 25600;
    localparam logic signed [DB_W-1:0] DB_FLOOR  = -16'sd25600;

    // Stage load strobes from the pipeline control to each lane
    typedef struct packed {
        logic load_env;
        logic adv1;
        logic adv2;
        logic adv3;
    } t_lane_ctl;

    // log2 of a Q1.30 value in [1,2) as a Q16 fraction, by repeated squaring.
    // Only ever called with constant arguments to build the lookup table.
    function automatic logic [LOG_W-1:0] log2_frac_q16(input logic [63:0] x_in);
        logic [63:0]      x;
        logic [LOG_W-1:0] res;
        x   = x_in;
        res = '0;
        for (int k = LOG_W - 1; k >= 0; k--) begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30)) begin
                x      = x >> 1;
                res[k] = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/selm_lane.sv =====
// One channel of the level meter: envelope follower and a three-stage dB converter.
// Depends on selm_pkg for widths, constants, the lane control struct and the log2 table.
`default_nettype none

module selm_lane
    import selm_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int ENV_FRAC_BITS  = 24,
    parameter int LOG_TABLE_BITS = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_lane_ctl                     i_ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [COEFF_W-1:0]            i_attack_coeff,
    input  wire logic [COEFF_W-1:0]            i_release_coeff,
    output logic signed [DB_W-1:0]             o_level_db
);

    localparam int EW     = ENV_FRAC_BITS + 1;
    localparam int P_W    = $clog2(EW);
    localparam int NR_W   = P_W + LOG_W;
    localparam int PR_W   = NR_W + DB_PER_OCT_W + 1;
    localparam int M_W    = PR_W - 24;
    localparam int TAB_N  = 1 << LOG_TABLE_BITS;
    localparam int SHL    = (ENV_FRAC_BITS >= SAMPLE_BITS - 1) ?
                            ENV_FRAC_BITS - (SAMPLE_BITS - 1) : 0;
    localparam int SHR    = (ENV_FRAC_BITS >= SAMPLE_BITS - 1) ?
                            0 : (SAMPLE_BITS - 1) - ENV_FRAC_BITS;
    localparam int PW_W   = COEFF_W + EW + 1;
    localparam logic [EW-1:0]    TINY_MAX  = EW'((64'd1 << ENV_FRAC_BITS) / 64'd1000000);
    localparam logic [PW_W-1:0]  STEP_RND  = PW_W'((64'd1 << COEFF_W) - 64'd1);
    localparam logic [PR_W-1:0]  DB_RND    = PR_W'(64'd1 << 23);

    // log2 fraction table, folded to constants at elaboration
    logic [LOG_W-1:0] w_log_tab [TAB_N];
    for (genvar g = 0; g < TAB_N; g++) begin : g_tab
        assign w_log_tab[g] = log2_frac_q16((64'd1 << 30) +
                                            (64'(g) << (30 - LOG_TABLE_BITS)));
    end

    // Rectify and scale the sample to Q1.ENV_FRAC_BITS
    logic [SAMPLE_BITS-1:0] w_abs;
    logic [EW-1:0]          w_mag;
    assign w_abs = i_sample[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - SAMPLE_BITS'(i_sample))
                                           : SAMPLE_BITS'(i_sample);
    assign w_mag = EW'(w_abs >> SHR) << SHL;

    // Envelope step, rounded away from zero
    logic [EW-1:0]      r_env;
    logic               w_rise;
    logic [EW-1:0]      w_diff;
    logic [COEFF_W-1:0] w_coeff;
    logic [PW_W-1:0]    w_prod;
    logic [EW-1:0]      w_step;
    logic [EW-1:0]      n_env;

    assign w_rise  = w_mag > r_env;
    assign w_diff  = w_rise ? (w_mag - r_env) : (r_env - w_mag);
    assign w_coeff = w_rise ? i_attack_coeff : i_release_coeff;
    assign w_prod  = PW_W'(w_coeff) * PW_W'(w_diff) + STEP_RND;
    assign w_step  = EW'(w_prod >> COEFF_W);
    assign n_env   = w_rise ? (r_env + w_step) : (r_env - w_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env <= '0;
        end else if (i_ctl.load_env) begin
            r_env <= n_env;
        end
    end

    // Stage 1: leading-one position and tiny-level check
    logic [P_W-1:0] w_lead;
    always_comb begin
        w_lead = '0;
        for (int i = 0; i < EW; i++) begin
            if (r_env[i]) begin
                w_lead = P_W'(i);
            end
        end
    end

    logic [EW-1:0]  r1_env;
    logic [P_W-1:0] r1_lead;
    logic           r1_tiny;
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv1) begin
            r1_env  <= r_env;
            r1_lead <= w_lead;
            r1_tiny <= (r_env <= TINY_MAX);
        end
    end

    // Stage 2: mantissa bits below the leading one, table lookup, -log2
    logic [EW+LOG_TABLE_BITS-1:0] w_ext;
    logic [LOG_TABLE_BITS-1:0]    w_frac;
    logic [P_W-1:0]               w_oct;
    logic [NR_W-1:0]              w_neg_log;

    assign w_ext     = {r1_env, LOG_TABLE_BITS'(0)};
    assign w_frac    = w_ext[r1_lead +: LOG_TABLE_BITS];
    assign w_oct     = P_W'(ENV_FRAC_BITS) - r1_lead;
    assign w_neg_log = {w_oct, LOG_W'(0)} - NR_W'(w_log_tab[w_frac]);

    logic [NR_W-1:0] r2_neg_log;
    logic            r2_tiny;
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv2) begin
            r2_neg_log <= w_neg_log;
            r2_tiny    <= r1_tiny;
        end
    end

    // Stage 3: scale to dB, round, apply the -100 dB floor
    logic [PR_W-1:0] w_db_prod;
    logic [M_W-1:0]  w_db_mag;
    assign w_db_prod = PR_W'(r2_neg_log) * PR_W'(DB_PER_OCT) + DB_RND;
    assign w_db_mag  = M_W'(w_db_prod >> 24);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv3) begin
            if (r2_tiny || (w_db_mag >= M_W'(DB_FLOOR_MAG))) begin
                o_level_db <= DB_FLOOR;
            end else begin
                o_level_db <= DB_W'(0) - DB_W'(w_db_mag);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stereo_envelope_level_meter_top.sv =====
// Top level of the stereo level meter: register port, pipeline control, lane merge.
// Depends on selm_pkg and instantiates two selm_lane channels.
// A frame accepted into the envelope stage passes the three dB stages and the output register.
// Throughput: one frame per cycle while the output is not stalled; the envelope update
// is a combinational multiply-add per lane, the dB conversion three stages behind it.
// Reset (synchronous, active low) zeroes both envelopes, empties the pipeline
// and loads the register defaults; no clearing pass is needed.
`default_nettype none

module stereo_envelope_level_meter_top
    import selm_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int ENV_FRAC_BITS  = 24,
    parameter int LOG_TABLE_BITS = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [3:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // frame input
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] i_right_sample,
    // level output
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [DB_W-1:0]             o_level_left_db,
    output logic signed [DB_W-1:0]             o_level_right_db
);

    localparam int NSTG = 5;

    // Configuration registers
    logic [COEFF_W-1:0] r_attack;
    logic [COEFF_W-1:0] r_release;
    logic               r_stereo;
    logic               w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            REG_ATTACK:  prdata = 32'(r_attack);
            REG_RELEASE: prdata = 32'(r_release);
            REG_STEREO:  prdata = 32'(r_stereo);
            default:     prdata = '0;
        endcase
    end

    // Pipeline valid bits: stage 0 is the envelope, stage 4 the output beat
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_rdy;
    logic            w_acc;

    assign w_rdy[NSTG-1] = !r_v[NSTG-1] || !i_out_stall;
    for (genvar k = 0; k < NSTG - 1; k++) begin : g_rdy
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
    end

    assign w_acc       = i_in_valid && w_rdy[0];
    assign o_in_stall  = !w_rdy[0];
    assign o_out_valid = r_v[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= '0;
            r_attack  <= ATTACK_RESET;
            r_release <= RELEASE_RESET;
            r_stereo  <= STEREO_RESET;
        end else begin
            // advance each stage that has room
            if (w_rdy[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            // register writes; unknown indexes drop
            if (w_cfg_wr) begin
                unique case (paddr[3:2])
                    REG_ATTACK:  r_attack  <= pwdata[COEFF_W-1:0];
                    REG_RELEASE: r_release <= pwdata[COEFF_W-1:0];
                    REG_STEREO:  r_stereo  <= pwdata[0];
                    default:     ;
                endcase
            end
        end
    end

    // Lane strobes; the right envelope holds in mono mode
    t_lane_ctl w_ctl_left;
    t_lane_ctl w_ctl_right;

    assign w_ctl_left.load_env  = w_acc;
    assign w_ctl_left.adv1      = w_rdy[1] && r_v[0];
    assign w_ctl_left.adv2      = w_rdy[2] && r_v[1];
    assign w_ctl_left.adv3      = w_rdy[3] && r_v[2];
    assign w_ctl_right.load_env = w_acc && r_stereo;
    assign w_ctl_right.adv1     = w_ctl_left.adv1;
    assign w_ctl_right.adv2     = w_ctl_left.adv2;
    assign w_ctl_right.adv3     = w_ctl_left.adv3;

    logic signed [DB_W-1:0] w_db_left;
    logic signed [DB_W-1:0] w_db_right;

    selm_lane #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .ENV_FRAC_BITS  (ENV_FRAC_BITS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_lane_left (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl_left),
        .i_sample        (i_left_sample),
        .i_attack_coeff  (r_attack),
        .i_release_coeff (r_release),
        .o_level_db      (w_db_left)
    );

    selm_lane #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .ENV_FRAC_BITS  (ENV_FRAC_BITS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_lane_right (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl_right),
        .i_sample        (i_right_sample),
        .i_attack_coeff  (r_attack),
        .i_release_coeff (r_release),
        .o_level_db      (w_db_right)
    );

    // Merge lanes into the output beat; mono mirrors the left level
    always_ff @(posedge i_clk) begin
        if (w_rdy[NSTG-1] && r_v[NSTG-2]) begin
            o_level_left_db  <= w_db_left;
            o_level_right_db <= r_stereo ? w_db_right : w_db_left;
        end
    end

    // Mono mode shows identical levels on both sides
    a_mono_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !r_stereo |-> o_level_right_db == o_level_left_db)
        else $error("mono output differs between channels");

    // The left level stays within the floor and full scale
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_level_left_db <= 16'sd0) && (o_level_left_db >= DB_FLOOR))
        else $error("left level out of range");

    // An accepted frame always lands in the envelope stage
    a_acc_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_v[0])
        else $error("accepted frame lost at envelope stage");

    // A full pipeline with a stalled output must block new frames
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_v) && i_out_stall |-> o_in_stall)
        else $error("frame accepted into a full stalled pipeline");

endmodule

`default_nettype wire

// ===== tb/stereo_envelope_level_meter_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the stereo envelope level meter: random frame stimulus,
// register writes over the APB port, and a bit-exact envelope and dB predictor.
// Depends on selm_pkg and stereo_envelope_level_meter_top.

module stereo_envelope_level_meter_top_tb
    import selm_pkg::*;
();

    localparam int SMP_BITS    = 16;
    localparam int ENV_FRAC    = 24;
    localparam int TAB_BITS    = 6;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_PAD   = 12;
    localparam int CYCLE_LIMIT = 200000;

    // Unmapped register slot; writes there must be ignored
    localparam logic [1:0] REG_SPARE = 2'd3;

    // Amplitude classes for the random program
    typedef enum int {
        AMP_QUIET,
        AMP_LOW,
        AMP_ANY,
        AMP_LOUD,
        AMP_ZERO
    } t_amp_class;

    typedef struct packed {
        logic signed [SMP_BITS-1:0] l_smp;
        logic signed [SMP_BITS-1:0] r_smp;
    } t_frame;

    typedef struct packed {
        logic signed [DB_W-1:0] l_db;
        logic signed [DB_W-1:0] r_db;
    } t_level_pair;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [3:0]                   paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic signed [SMP_BITS-1:0]   i_left_sample = '0;
    logic signed [SMP_BITS-1:0]   i_right_sample = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic signed [DB_W-1:0]       o_level_left_db;
    logic signed [DB_W-1:0]       o_level_right_db;

    // Predictor state and register shadow
    logic [63:0]      env_l_q = '0;
    logic [63:0]      env_r_q = '0;
    logic [COEFF_W-1:0] attack_cfg = ATTACK_RESET;
    logic [COEFF_W-1:0] release_cfg = RELEASE_RESET;
    logic             stereo_cfg = STEREO_RESET;
    logic [LOG_W-1:0] log2_tab [1 << TAB_BITS];

    t_frame      frame_q [$];
    t_level_pair level_q [$];
    int          mismatches = 0;
    int          hold_req = 0;
    bit          no_idle = 1'b0;
    int          cycles = 0;

    stereo_envelope_level_meter_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_left_sample    (i_left_sample),
        .i_right_sample   (i_right_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_level_left_db  (o_level_left_db),
        .o_level_right_db (o_level_right_db)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Rectify a sample and scale it to Q1.24; full negative scale maps to 1.0
    function automatic logic [63:0] sample_mag(input logic signed [SMP_BITS-1:0] s);
        logic [SMP_BITS:0] a;
        a = s[SMP_BITS-1] ? ((17'd1 << SMP_BITS) - {1'b0, s}) : {1'b0, s};
        return 64'(a) << (ENV_FRAC - (SMP_BITS - 1));
    endfunction

    // One attack/release step, with the step rounded away from zero
    function automatic logic [63:0] env_track(input logic [63:0] env, input logic [63:0] mag,
                                              input logic [COEFF_W-1:0] rise,
                                              input logic [COEFF_W-1:0] fall);
        logic [63:0] rnd;
        rnd = (64'd1 << COEFF_W) - 64'd1;
        if (mag > env)
            return env + ((64'(rise) * (mag - env) + rnd) >> COEFF_W);
        return env - ((64'(fall) * (env - mag) + rnd) >> COEFF_W);
    endfunction

    // Envelope to Q8.8 dB: leading-one position plus table lookup, floored at -100 dB
    function automatic logic signed [DB_W-1:0] env_to_db(input logic [63:0] env);
        int          lead;
        logic [63:0] fidx;
        logic [63:0] mag;
        longint      lg;
        if (env * 64'd1000000 <= (64'd1 << ENV_FRAC))
            return DB_FLOOR;
        lead = 0;
        for (int b = 0; b < 64; b++) begin
            if (env[b])
                lead = b;
        end
        if (lead >= TAB_BITS)
            fidx = (env >> (lead - TAB_BITS)) & ((64'd1 << TAB_BITS) - 1);
        else
            fidx = (env << (TAB_BITS - lead)) & ((64'd1 << TAB_BITS) - 1);
        lg = longint'(lead) * 65536 + longint'(log2_tab[fidx]) - longint'(ENV_FRAC) * 65536;
        if (lg >= 0)
            return '0;
        mag = (64'(-lg) * 64'(DB_PER_OCT) + (64'd1 << 23)) >> 24;
        if (mag >= 64'(DB_FLOOR_MAG))
            return DB_FLOOR;
        return DB_W'(0) - DB_W'(mag);
    endfunction

    function automatic void queue_frame(input int l, input int r);
        t_frame f;
        f.l_smp = SMP_BITS'(l);
        f.r_smp = SMP_BITS'(r);
        frame_q.push_back(f);
    endfunction

    function automatic int sample_of(input t_amp_class kind);
        int v;
        case (kind)
            AMP_QUIET: v = $urandom_range(0, 2) - 1;
            AMP_LOW:   v = $urandom_range(0, 510) - 255;
            AMP_ANY:   v = $urandom_range(0, 65535) - 32768;
            AMP_LOUD: begin
                case ($urandom_range(0, 3))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = $urandom_range(24000, 32767);
                    default: v = -$urandom_range(24000, 32767);
                endcase
            end
            default:   v = 0;
        endcase
        return v;
    endfunction

    // Queue a program of segments, each holding one loudness class per channel
    function automatic void queue_program(input int count);
        int         seg;
        t_amp_class kind_l;
        t_amp_class kind_r;
        seg = 0;
        kind_l = AMP_ZERO;
        kind_r = AMP_ZERO;
        repeat (count) begin
            if (seg == 0) begin
                seg = $urandom_range(3, 40);
                kind_l = t_amp_class'($urandom_range(0, 4));
                kind_r = t_amp_class'($urandom_range(0, 4));
            end
            seg--;
            queue_frame(sample_of(kind_l), sample_of(kind_r));
        end
    endfunction

    function automatic logic [COEFF_W-1:0] pick_coeff();
        case ($urandom_range(0, 2))
            0:       return COEFF_W'($urandom_range(1, 1 << 16));
            1:       return COEFF_W'($urandom_range(1 << 16, 1 << 22));
            default: return COEFF_W'($urandom);
        endcase
    endfunction

    // Setup beat then access beat; the register takes the value at the access edge
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ATTACK:  attack_cfg = value[COEFF_W-1:0];
            REG_RELEASE: release_cfg = value[COEFF_W-1:0];
            REG_STEREO:  stereo_cfg = value[0];
            default: ;
        endcase
    endtask

    // Hold until every queued frame is taken and every level beat has arrived
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (frame_q.size() != 0 || level_q.size() != 0 || i_in_valid);
        repeat (DRAIN_PAD) @(negedge i_clk);
    endtask

    // Sender: predict each accepted frame, then offer the next one or idle a burst
    always @(posedge i_clk) begin : frame_driver
        int          gap_left;
        t_frame      f;
        t_level_pair lv;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                env_l_q = env_track(env_l_q, sample_mag(i_left_sample), attack_cfg, release_cfg);
                lv.l_db = env_to_db(env_l_q);
                if (stereo_cfg) begin
                    env_r_q = env_track(env_r_q, sample_mag(i_right_sample),
                                        attack_cfg, release_cfg);
                    lv.r_db = env_to_db(env_r_q);
                end else begin
                    lv.r_db = lv.l_db;
                end
                level_q.push_back(lv);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (frame_q.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(0, 6);
                    i_in_valid <= 1'b0;
                end else begin
                    f = frame_q.pop_front();
                    i_left_sample  <= f.l_smp;
                    i_right_sample <= f.r_smp;
                    i_in_valid     <= 1'b1;
                end
            end
        end
    end

    // Receiver: long hold-off on request, otherwise random stall bursts
    always @(posedge i_clk) begin : level_receiver
        int stall_left;
        int hold_left;
        int holds_seen;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            holds_seen = hold_req;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (holds_seen != hold_req) begin
            holds_seen = hold_req;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each level beat with the oldest predicted pair
    always @(posedge i_clk) begin : level_checker
        t_level_pair want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (level_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected level beat: L=%0d R=%0d",
                             o_level_left_db, o_level_right_db);
            end else begin
                want = level_q.pop_front();
                if (want.l_db !== o_level_left_db || want.r_db !== o_level_right_db) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("level mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                                 want.l_db, want.r_db, o_level_left_db, o_level_right_db);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [63:0] x;
        logic [LOG_W-1:0] acc;
        // Build the log2 fraction table by repeated squaring in Q1.30
        for (int i = 0; i < (1 << TAB_BITS); i++) begin
            x = (64'd1 << 30) + (64'(i) << (30 - TAB_BITS));
            acc = '0;
            for (int k = LOG_W - 1; k >= 0; k--) begin
                x = (x * x) >> 30;
                if (x >= (64'd2 << 30)) begin
                    x = x >> 1;
                    acc[k] = 1'b1;
                end
            end
            log2_tab[i] = acc;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: silence, smallest and full-scale samples
        @(negedge i_clk);
        queue_frame(0, 0);
        queue_frame(1, -1);
        queue_frame(-1, 1);
        queue_frame(32767, -32768);
        queue_frame(-32768, 32767);
        queue_frame(16'sh5555, 16'shAAAA);
        queue_frame(0, 0);
        wait_drained();

        // Unmapped write, then near-unity coefficients: jump to full scale and back
        reg_write(REG_SPARE, 32'hFFFF_FFFF);
        reg_write(REG_ATTACK, 32'h00FF_FFFF);
        reg_write(REG_RELEASE, 32'h00FF_FFFF);
        @(negedge i_clk);
        queue_frame(-32768, 1);
        queue_frame(0, 32767);
        queue_frame(32767, 0);
        queue_frame(1, 1);
        queue_frame(0, 0);
        wait_drained();

        // Mono, slow attack from zero: tiny envelope, then a level below the floor
        reg_write(REG_ATTACK, 32'h0008_0000);
        reg_write(REG_STEREO, 32'd0);
        @(negedge i_clk);
        queue_frame(1, -32768);
        queue_frame(1, 5);
        queue_frame(-1, 0);
        queue_frame(-32768, 123);
        queue_frame(0, -1);
        queue_frame(0, 0);
        wait_drained();

        // Stereo at the reset coefficients; receiver holds off so the input backs up
        reg_write(REG_ATTACK, 32'(ATTACK_RESET));
        reg_write(REG_RELEASE, 32'(RELEASE_RESET));
        reg_write(REG_STEREO, 32'd1);
        @(negedge i_clk);
        hold_req = hold_req + 1;
        queue_program(280);
        wait_drained();

        // Mono with random coefficients
        reg_write(REG_ATTACK, 32'(pick_coeff()));
        reg_write(REG_RELEASE, 32'(pick_coeff()));
        reg_write(REG_STEREO, 32'd0);
        @(negedge i_clk);
        queue_program(170);
        wait_drained();

        // Frozen attack, instant release
        reg_write(REG_ATTACK, 32'd0);
        reg_write(REG_RELEASE, 32'h00FF_FFFF);
        reg_write(REG_STEREO, 32'd1);
        @(negedge i_clk);
        queue_program(60);
        wait_drained();

        // Instant attack, frozen release
        reg_write(REG_ATTACK, 32'h00FF_FFFF);
        reg_write(REG_RELEASE, 32'd0);
        @(negedge i_clk);
        queue_program(60);
        wait_drained();

        // Last stretch at full rate, no idling on either side
        reg_write(REG_ATTACK, 32'(pick_coeff()));
        reg_write(REG_RELEASE, 32'(pick_coeff()));
        @(negedge i_clk);
        no_idle = 1'b1;
        queue_program(220);
        wait_drained();

        if (mismatches == 0 && level_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== stereo_envelope_level_meter_top.f =====
rtl/selm_pkg.sv
rtl/selm_lane.sv
rtl/stereo_envelope_level_meter_top.sv
tb/stereo_envelope_level_meter_top_tb.sv
